// ----- rtl/cms_pkg.sv -----
// Shared widths, state encoding and handshake structs for the cluster merge test.
// Used by cms_mul, cms_div and cluster_merge_similarity_test; depends on nothing.
package cms_pkg;

    localparam int CNT_W       = 16;             // member and bit counts on the ports
    localparam int SUM_W       = CNT_W + 1;      // combined size N and combined count L
    localparam int SH_W        = SUM_W + 1;      // L plus centroid, also N + 1
    localparam int DIVD_W      = SUM_W + 2;      // 2L + N
    localparam int DIVS_W      = SUM_W + 1;      // 2N
    localparam int DCNT_W      = $clog2(DIVD_W + 1);

    localparam int PS_W        = 30;             // plain sum
    localparam int PQ_W        = 47;             // plain square sum
    localparam int SS_W        = 31;             // shifted sum
    localparam int SQ_W        = 49;             // shifted square sum

    localparam int THR_W       = 17;
    localparam logic [THR_W-1:0] THR_RESET = 17'd45875;

    localparam int D_W         = SQ_W + 3;       // signed similarity denominator
    localparam int PD_W        = SQ_W + 1;       // signed similarity numerator
    localparam int P_W         = SQ_W;           // numerator magnitude
    localparam int Q_W         = SQ_W + 1;       // denominator magnitude

    localparam int SER_W       = Q_W;            // serial multiplier operand
    localparam int MUL_W       = 117;            // product width, largest term before scaling
    localparam int FRAC_SHIFT  = 15;             // 2 * 2^15 against a Q16 threshold
    localparam int ACC_W       = MUL_W + FRAC_SHIFT;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_COL_GO,
        ST_COL_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_D1_GO,
        ST_D1_WAIT,
        ST_D2_GO,
        ST_D2_WAIT,
        ST_T1A_GO,
        ST_T1A_WAIT,
        ST_T1B_GO,
        ST_T1B_WAIT,
        ST_T2A_GO,
        ST_T2A_WAIT,
        ST_T2B_GO,
        ST_T2B_WAIT,
        ST_T3A_GO,
        ST_T3A_WAIT,
        ST_T3B_GO,
        ST_T3B_WAIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] mcand;
        logic [SER_W-1:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic             busy;
        logic [MUL_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [DIVD_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic           p_neg;
        logic [P_W-1:0] p_mag;
        logic [Q_W-1:0] q_mag;
    } sim_t;

endpackage

// ----- rtl/cms_mul.sv -----
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle, stops early at zero.
// Depends on cms_pkg for widths and the request/response structs.
module cms_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  cms_pkg::mul_req_t req,
    output cms_pkg::mul_rsp_t rsp
);
    import cms_pkg::*;

    logic             busy_reg;
    logic [MUL_W-1:0] mcand_reg;
    logic [SER_W-1:0] mplier_reg;
    logic [MUL_W-1:0] prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            prod_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else if (mplier_reg[0])
            begin
                prod_reg <= prod_reg + mcand_reg;
            end
        end
    end

    // operand shift registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mcand_reg  <= req.mcand;
            mplier_reg <= req.mplier;
        end
        else if (busy_reg)
        begin
            mcand_reg  <= {mcand_reg[MUL_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[SER_W-1:1]};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.prod = prod_reg;

`ifndef SYNTHESIS
    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && !req.start |=> $stable(prod_reg))
        else $error("product changed while multiplier idle");
`endif

endmodule

// ----- rtl/cms_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient shifted into the dividend register.
// Depends on cms_pkg for widths and the request/response structs.
module cms_div (
    input  logic              clk,
    input  logic              rst_n,
    input  cms_pkg::div_req_t req,
    output cms_pkg::div_rsp_t rsp
);
    import cms_pkg::*;

    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DIVD_W);

    logic [DCNT_W-1:0] cnt_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVD_W-1:0] dvd_reg;
    logic [DIVS_W-1:0] dvs_reg;

    logic [DIVS_W+1:0] trial;
    logic              fits;

    always_comb
    begin
        trial = {1'b0, rem_reg, dvd_reg[DIVD_W-1]} - {2'b00, dvs_reg};
        fits  = ~trial[DIVS_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            dvd_reg <= '0;
        end
        else if (req.start)
        begin
            cnt_reg <= DIV_STEPS;
            dvd_reg <= req.dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - DCNT_W'(1);
            dvd_reg <= {dvd_reg[DIVD_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            // subtract when the trial remainder fits, otherwise shift the bit in
            rem_reg <= fits ? trial[DIVS_W-1:0] : {rem_reg[DIVS_W-2:0], dvd_reg[DIVD_W-1]};
        end
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.quot = dvd_reg;

`ifndef SYNTHESIS
    a_quot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 && !req.start |=> $stable(dvd_reg))
        else $error("quotient changed while divider idle");
`endif

endmodule

// ----- rtl/cluster_merge_similarity_test.sv -----
// Top level of the cluster merge test: sequencer, column accumulators and final compare.
// Depends on cms_pkg, cms_mul and cms_div.
//
// Input channel (in_valid / in_stall): one transaction per fingerprint column with both
// member counts, both set-bit counts and last_column. in_stall is high while a column
// or the final compare is in progress.
// Output channel (out_valid / out_stall): one may_merge transaction after each column
// marked last_column, none for the others. A result held in the output register does
// not block new columns; only the next result waits for it at its final step.
// cfg_wr_en / cfg_wr_data: write the Q16 merge threshold, taken at once.
// Sequence: a column holds in_stall through the centroid division (19 quotient bits; the
// square of L runs beside it) and then the square of L + C, on the serial divider and
// the shared bit-serial multiplier. A last column adds eight serial products on the
// multiplier and then loads the result register that drives may_merge.
// Reset: rst_n clears the sums, empties the output register and restores threshold 45875.
module cluster_merge_similarity_test (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [cms_pkg::THR_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [cms_pkg::CNT_W-1:0]  count_a,
    input  logic [cms_pkg::CNT_W-1:0]  count_b,
    input  logic [cms_pkg::CNT_W-1:0]  bits_a,
    input  logic [cms_pkg::CNT_W-1:0]  bits_b,
    input  logic                       last_column,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       may_merge
);
    import cms_pkg::*;

    // Similarity terms: J = (Q - S) / (2x - S - Q) with x = n*S from the multiplier.
    // Denominator zero gives 0/1; a negative denominator flips both signs.
    function automatic sim_t sim_terms(input logic [SS_W-1:0] s,
                                       input logic [SQ_W-1:0] q,
                                       input logic [SQ_W-1:0] x);
        logic [D_W-1:0]  d;
        logic [D_W-1:0]  d_abs;
        logic [PD_W-1:0] pd;
        logic [PD_W-1:0] pd_abs;
        sim_t            r;
        d      = {{(D_W-SQ_W-1){1'b0}}, x, 1'b0}
               - {{(D_W-SS_W){1'b0}}, s}
               - {{(D_W-SQ_W){1'b0}}, q};
        pd     = {{(PD_W-SQ_W){1'b0}}, q} - {{(PD_W-SS_W){1'b0}}, s};
        d_abs  = d[D_W-1] ? (D_W'(0) - d) : d;
        pd_abs = pd[PD_W-1] ? (PD_W'(0) - pd) : pd;
        if (d == '0)
        begin
            r.p_neg = 1'b0;
            r.p_mag = '0;
            r.q_mag = Q_W'(1);
        end
        else
        begin
            r.p_neg = pd[PD_W-1] ^ d[D_W-1];
            r.p_mag = pd_abs[P_W-1:0];
            r.q_mag = d_abs[Q_W-1:0];
        end
        return r;
    endfunction

    state_t state_reg, state_next;

    logic             out_valid_reg, out_valid_next;
    logic             may_merge_reg;
    logic [THR_W-1:0] threshold_q16_reg;

    logic [PS_W-1:0]  plain_sum_reg;
    logic [PQ_W-1:0]  plain_square_sum_reg;
    logic [SS_W-1:0]  shifted_sum_reg;
    logic [SQ_W-1:0]  shifted_square_sum_reg;

    // column payload and intermediate terms
    logic [SUM_W-1:0]   n_reg;
    logic [SUM_W-1:0]   l_reg;
    logic               last_reg;
    logic [2*SUM_W-1:0] lsq_reg;
    logic [SH_W-1:0]    sh_reg;
    logic [Q_W-1:0]     q1_reg;
    logic [Q_W-1:0]     q2_reg;
    logic [P_W-1:0]     p1_mag_reg;
    logic [P_W-1:0]     p2_mag_reg;
    logic               p1_neg_reg;
    logic               p2_neg_reg;
    logic [ACC_W-1:0]   gain_reg;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic             in_accept;
    logic             out_free;
    logic             load_result;
    logic [SH_W-1:0]  n_plus;
    logic [SUM_W-1:0] m_mag;
    logic             m_neg;
    logic [SUM_W-1:0] cent;
    logic [ACC_W-1:0] prod_scaled;
    logic [ACC_W-1:0] prod_ext;
    sim_t             sim_shift;
    sim_t             sim_plain;

    cms_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    cms_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_accept   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign load_result = (state_reg == ST_RESULT) && out_free;

    assign n_plus      = SH_W'(n_reg) + SH_W'(1);
    assign m_neg       = (n_reg == '0);
    assign m_mag       = m_neg ? SUM_W'(1) : (n_reg - SUM_W'(1));
    // empty pair: centroid taken as zero
    assign cent        = (n_reg == '0) ? '0 : div_rsp.quot[SUM_W-1:0];
    assign prod_scaled = {mul_rsp.prod, {FRAC_SHIFT{1'b0}}};
    assign prod_ext    = ACC_W'(mul_rsp.prod);

    always_comb
    begin
        sim_shift = sim_terms(shifted_sum_reg, shifted_square_sum_reg,
                              mul_rsp.prod[SQ_W-1:0]);
        sim_plain = sim_terms(SS_W'(plain_sum_reg), SQ_W'(plain_square_sum_reg),
                              mul_rsp.prod[SQ_W-1:0]);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_accept) state_next = ST_COL_GO;
            ST_COL_GO:   state_next = ST_COL_WAIT;
            ST_COL_WAIT: if (!mul_rsp.busy && !div_rsp.busy) state_next = ST_SQ_GO;
            ST_SQ_GO:    state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:  if (!mul_rsp.busy) state_next = last_reg ? ST_D1_GO : ST_IDLE;
            ST_D1_GO:    state_next = ST_D1_WAIT;
            ST_D1_WAIT:  if (!mul_rsp.busy) state_next = ST_D2_GO;
            ST_D2_GO:    state_next = ST_D2_WAIT;
            ST_D2_WAIT:  if (!mul_rsp.busy) state_next = ST_T1A_GO;
            ST_T1A_GO:   state_next = ST_T1A_WAIT;
            ST_T1A_WAIT: if (!mul_rsp.busy) state_next = ST_T1B_GO;
            ST_T1B_GO:   state_next = ST_T1B_WAIT;
            ST_T1B_WAIT: if (!mul_rsp.busy) state_next = ST_T2A_GO;
            ST_T2A_GO:   state_next = ST_T2A_WAIT;
            ST_T2A_WAIT: if (!mul_rsp.busy) state_next = ST_T2B_GO;
            ST_T2B_GO:   state_next = ST_T2B_WAIT;
            ST_T2B_WAIT: if (!mul_rsp.busy) state_next = ST_T3A_GO;
            ST_T3A_GO:   state_next = ST_T3A_WAIT;
            ST_T3A_WAIT: if (!mul_rsp.busy) state_next = ST_T3B_GO;
            ST_T3B_GO:   state_next = ST_T3B_WAIT;
            ST_T3B_WAIT: if (!mul_rsp.busy) state_next = ST_RESULT;
            ST_RESULT:   if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // unit requests and input stall
    always_comb
    begin
        in_stall         = (state_reg != ST_IDLE);
        mul_req.start    = 1'b0;
        mul_req.mcand    = '0;
        mul_req.mplier   = '0;
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, l_reg, 1'b0} + DIVD_W'(n_reg);
        div_req.divisor  = {n_reg, 1'b0};
        case (state_reg)
            ST_COL_GO:
            begin
                // square of L runs beside the centroid division
                div_req.start  = 1'b1;
                mul_req.start  = 1'b1;
                mul_req.mcand  = MUL_W'(l_reg);
                mul_req.mplier = SER_W'(l_reg);
            end
            ST_SQ_GO:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = MUL_W'(sh_reg);
                mul_req.mplier = SER_W'(sh_reg);
            end
            ST_D1_GO:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = MUL_W'(shifted_sum_reg);
                mul_req.mplier = SER_W'(n_plus);
            end
            ST_D2_GO:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = MUL_W'(plain_sum_reg);
                mul_req.mplier = SER_W'(n_reg);
            end
            ST_T1A_GO:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = MUL_W'(p1_mag_reg);
                mul_req.mplier = SER_W'(n_plus);
            end
            ST_T1B_GO:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = mul_rsp.prod;
                mul_req.mplier = q2_reg;
            end
            ST_T2A_GO:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = MUL_W'(p2_mag_reg);
                mul_req.mplier = SER_W'(m_mag);
            end
            ST_T2B_GO:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = mul_rsp.prod;
                mul_req.mplier = q1_reg;
            end
            ST_T3A_GO:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = MUL_W'(q1_reg);
                mul_req.mplier = SER_W'(threshold_q16_reg);
            end
            ST_T3B_GO:
            begin
                mul_req.start  = 1'b1;
                mul_req.mcand  = mul_rsp.prod;
                mul_req.mplier = q2_reg;
            end
            default:
            begin
                mul_req.start  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state, threshold and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= ST_IDLE;
            out_valid_reg          <= 1'b0;
            threshold_q16_reg      <= THR_RESET;
            plain_sum_reg          <= '0;
            plain_square_sum_reg   <= '0;
            shifted_sum_reg        <= '0;
            shifted_square_sum_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                threshold_q16_reg <= cfg_wr_data;
            end
            if (state_reg == ST_SQ_WAIT && !mul_rsp.busy)
            begin
                // sums wrap at their own widths
                plain_sum_reg          <= plain_sum_reg + PS_W'(l_reg);
                plain_square_sum_reg   <= plain_square_sum_reg + PQ_W'(lsq_reg);
                shifted_sum_reg        <= shifted_sum_reg + SS_W'(sh_reg);
                shifted_square_sum_reg <= shifted_square_sum_reg
                                          + SQ_W'(mul_rsp.prod[2*SH_W-1:0]);
            end
            else if (load_result)
            begin
                // drop the pair's sums once its verdict is out
                plain_sum_reg          <= '0;
                plain_square_sum_reg   <= '0;
                shifted_sum_reg        <= '0;
                shifted_square_sum_reg <= '0;
            end
        end
    end

    // payload and intermediate terms
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            n_reg    <= SUM_W'(count_a) + SUM_W'(count_b);
            l_reg    <= SUM_W'(bits_a) + SUM_W'(bits_b);
            last_reg <= last_column;
        end
        case (state_reg)
            ST_COL_WAIT:
            begin
                if (!mul_rsp.busy && !div_rsp.busy)
                begin
                    sh_reg  <= SH_W'(l_reg) + SH_W'(cent);
                    lsq_reg <= mul_rsp.prod[2*SUM_W-1:0];
                end
            end
            ST_D1_WAIT:
            begin
                if (!mul_rsp.busy)
                begin
                    q1_reg     <= sim_shift.q_mag;
                    p1_mag_reg <= sim_shift.p_mag;
                    p1_neg_reg <= sim_shift.p_neg;
                end
            end
            ST_D2_WAIT:
            begin
                if (!mul_rsp.busy)
                begin
                    q2_reg     <= sim_plain.q_mag;
                    p2_mag_reg <= sim_plain.p_mag;
                    p2_neg_reg <= sim_plain.p_neg;
                end
            end
            ST_T1B_WAIT:
            begin
                // gain = 2^15 * (N+1) * p1 * q2 first
                if (!mul_rsp.busy)
                begin
                    gain_reg <= p1_neg_reg ? (ACC_W'(0) - prod_scaled) : prod_scaled;
                end
            end
            ST_T2B_WAIT:
            begin
                // take away 2^15 * (N-1) * p2 * q1, with N-1 signed
                if (!mul_rsp.busy)
                begin
                    gain_reg <= (m_neg ^ p2_neg_reg) ? (gain_reg + prod_scaled)
                                                     : (gain_reg - prod_scaled);
                end
            end
            ST_T3B_WAIT:
            begin
                // take away threshold * q1 * q2
                if (!mul_rsp.busy)
                begin
                    gain_reg <= gain_reg - prod_ext;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    may_merge_reg <= ~gain_reg[ACC_W-1];
                end
            end
            default:
            begin
                sh_reg <= sh_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign may_merge = may_merge_reg;

`ifndef SYNTHESIS
    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !mul_rsp.busy && !div_rsp.busy)
        else $error("input open while an arithmetic unit is still busy");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_COL_GO)
        else $error("accepted column did not start the column sequence");

    a_square_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQ_GO |=> mul_rsp.busy)
        else $error("multiplier did not take the square request");

    a_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> out_valid_reg && plain_sum_reg == '0
                        && shifted_square_sum_reg == '0)
        else $error("result loaded without clearing the pair sums");
`endif

endmodule
